/* hdl/wrld_pkg.sv */
// Shared types and constants for the word run-length decoder.
// No dependencies; used by every module in hdl/.
package wrld_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned CountW = 31;

    localparam logic [WordW-1:0] END_MARK  = 32'hC000_0000;
    localparam logic [WordW-1:0] TOTAL_MAX = 32'hFFFF_FFFF;

    // One expanded result beat
    typedef struct packed {
        logic [WordW-1:0]  total_words;
        logic              is_last;
        logic [CountW-1:0] repeat_count;
        logic [WordW-1:0]  out_word;
    } res_t;

endpackage

/* hdl/wrld_decode.sv */
// Input register, run state and header decode of the word run-length decoder.
// Depends on wrld_pkg.
module wrld_decode
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [wrld_pkg::WordW-1:0] in_word,
    output logic                      res_valid,
    input  logic                      res_ready,
    output wrld_pkg::res_t            res
);

    logic                        word_valid_reg;
    logic [wrld_pkg::WordW-1:0]  word_reg;
    logic                        lit_reg;
    logic                        lit_next;
    logic [wrld_pkg::CountW-1:0] left_reg;
    logic [wrld_pkg::CountW-1:0] left_next;
    logic [wrld_pkg::WordW-1:0]  total_reg;
    logic [wrld_pkg::WordW-1:0]  total_next;

    logic                        has_result;
    logic                        advance;
    logic [wrld_pkg::CountW-1:0] add_n;
    logic [wrld_pkg::WordW:0]    sum;
    logic [wrld_pkg::WordW-1:0]  sat_sum;

    assign add_n   = lit_reg ? wrld_pkg::CountW'(1) : word_reg[wrld_pkg::CountW-1:0];
    assign sum     = {1'b0, total_reg} + {2'b0, add_n};
    assign sat_sum = sum[wrld_pkg::WordW] ? wrld_pkg::TOTAL_MAX : sum[wrld_pkg::WordW-1:0];

    always_comb
    begin
        has_result = 1'b0;
        lit_next   = lit_reg;
        left_next  = left_reg;
        total_next = total_reg;
        res        = '0;
        if (lit_reg)
        begin
            // copy the word out as a literal, whatever it holds
            has_result       = 1'b1;
            total_next       = sat_sum;
            left_next        = left_reg - wrld_pkg::CountW'(1);
            lit_next         = (left_next != '0);
            res.out_word     = word_reg;
            res.repeat_count = wrld_pkg::CountW'(1);
            res.total_words  = sat_sum;
        end
        else if (word_reg == wrld_pkg::END_MARK)
        begin
            has_result      = 1'b1;
            total_next      = '0;
            res.is_last     = 1'b1;
            res.total_words = total_reg;
        end
        else if (word_reg[wrld_pkg::WordW-1])
        begin
            // zero run; a zero length emits nothing
            if (add_n != '0)
            begin
                has_result       = 1'b1;
                total_next       = sat_sum;
                res.repeat_count = add_n;
                res.total_words  = sat_sum;
            end
        end
        else
        begin
            left_next = word_reg[wrld_pkg::CountW-1:0];
            lit_next  = (left_next != '0);
        end
    end

    assign res_valid = word_valid_reg && has_result;
    assign advance   = word_valid_reg && (!has_result || res_ready);
    assign in_ready  = !word_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= 1'b0;
            lit_reg        <= 1'b0;
            left_reg       <= '0;
            total_reg      <= '0;
        end
        else
        begin
            if (in_ready)
                word_valid_reg <= in_valid;
            if (advance)
            begin
                lit_reg   <= lit_next;
                left_reg  <= left_next;
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            word_reg <= in_word;
    end

endmodule

/* hdl/wrld_out_reg.sv */
// Result register of the word run-length decoder: holds one beat for the receiver.
// Depends on wrld_pkg.
module wrld_out_reg
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  wrld_pkg::res_t in_res,
    output logic           out_valid,
    input  logic           out_ready,
    output wrld_pkg::res_t out_res
);

    logic           valid_reg;
    wrld_pkg::res_t res_reg;

    // take a new beat when empty or when the held one leaves this cycle
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            res_reg <= in_res;
    end

endmodule

/* hdl/word_run_length_decoder.sv */
// Word run-length decoder, top level.
// Depends on wrld_pkg, wrld_decode and wrld_out_reg.
//
// Usage:
//   Slave channel s_axis_* carries compressed 32-bit words, one per beat.
//   Master channel m_axis_* carries expanded results; tlast marks the end
//   result, which carries the image total and clears it.
//   A header word that expands to nothing (zero-length run or literal
//   header) is consumed without an output beat.
// Path: an accepted word is held in the input register, decoded, and its
//   result beat is held in the result register.
// Throughput: one word per cycle, sustained while m_axis_tready is high; the run state
//   is updated in the single decode step between the two registers.
// Reset: both registers empty, header mode, total cleared; s_axis_tready
//   is high straight after reset.
// Stall: while m_axis_tready is low the result register holds its beat;
//   the next word that gives a beat waits in the input register, then s_axis_tready drops.
module word_run_length_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] comp_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,  // [31:0] out_word, [62:32] repeat_count,
                                       // [94:63] total_words, [95] zero
    output logic        m_axis_tlast   // is_last
);

    logic           res_valid;
    logic           res_ready;
    wrld_pkg::res_t res;
    wrld_pkg::res_t out_res;

    wrld_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_word   (s_axis_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    wrld_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_res    (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {1'b0, out_res.total_words, out_res.repeat_count, out_res.out_word};
    assign m_axis_tlast = out_res.is_last;

endmodule
